[rtl/core/annexb_nal_splitter_top_assert.svh]
// Assertion macros for the Annex B NAL splitter checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ANNEXB_NAL_SPLITTER_TOP_ASSERT_SVH
`define ANNEXB_NAL_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define ANX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ANX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/annexb_pkg.sv]
// Package for the Annex B NAL splitter: item types, state, constants and
// the per-byte emit function. No dependencies.
`timescale 1ns / 1ps

package annexb_pkg;

    localparam int MAX_RES = 5;
    localparam int IDX_W   = 3;

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] EPB_BYTE   = 8'h03;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_MARKER  = 1'b1;

    localparam logic [1:0] HELD_MAX = 2'd3;
    localparam logic [1:0] RUN_MAX  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic       nal_first;
        logic [4:0] nal_type;
        logic [1:0] nal_ref_idc;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] held_zero_count;
        logic [1:0] emitted_zero_run;
        logic       nal_open;
        logic [7:0] header_byte;
    } t_state;

    typedef struct packed {
        t_out_item [MAX_RES-1:0] res;
        logic [IDX_W-1:0]        cnt;
    } t_burst;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // One byte into the current NAL, with emulation prevention removal.
    function automatic void emit_byte(input t_state s, input logic [7:0] b,
                                      output t_state so, output logic put,
                                      output t_out_item r);
        logic first;
        so    = s;
        put   = 1'b0;
        r     = '0;
        first = 1'b0;
        if (b == EPB_BYTE && s.emitted_zero_run == RUN_MAX) begin
            so.emitted_zero_run = 2'd0;
        end else begin
            put = 1'b1;
            if (!s.nal_open) begin
                so.nal_open    = 1'b1;
                so.header_byte = b;
                first          = 1'b1;
            end
            r.item_kind    = KIND_PAYLOAD;
            r.payload_byte = b;
            r.nal_first    = first;
            r.nal_type     = so.header_byte[4:0];
            r.nal_ref_idc  = so.header_byte[6:5];
            if (b == ZERO_BYTE) begin
                so.emitted_zero_run = (s.emitted_zero_run < RUN_MAX)
                                    ? s.emitted_zero_run + 2'd1 : RUN_MAX;
            end else begin
                so.emitted_zero_run = 2'd0;
            end
        end
    endfunction

endpackage

[rtl/core/annexb_stream_if.sv]
// Valid/ready channel carrying one item of type T.
// Depends on nothing; specialized with the annexb_pkg item types.
`timescale 1ns / 1ps

interface annexb_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/annexb_front.sv]
// Front end: accepts raw bytes, tracks start-code state and builds the
// burst of results for each byte. Depends on annexb_pkg and annexb_stream_if.
`timescale 1ns / 1ps

module annexb_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    annexb_stream_if.sink          i_in,
    input  annexb_pkg::t_qstat     i_qstat,
    output logic                   o_push,
    output annexb_pkg::t_burst     o_burst
);
    import annexb_pkg::*;

    t_state r_st;
    t_state n_st;
    logic   accept;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && (o_burst.cnt != '0);

    always_comb begin : build
        t_state    st;
        t_state    e_st;
        logic      e_put;
        t_out_item e_res;
        t_burst    bu;
        logic [7:0] b;

        st    = r_st;
        e_st  = r_st;
        e_put = 1'b0;
        e_res = '0;
        bu    = '0;
        b     = i_in.data.data_byte;

        if (b == START_BYTE && st.held_zero_count >= 2'd2) begin
            // Start code: held zeros vanish, an open NAL is closed.
            st.held_zero_count = 2'd0;
            if (st.nal_open) begin
                bu.res[bu.cnt]          = '0;
                bu.res[bu.cnt].item_kind = KIND_MARKER;
                bu.res[bu.cnt].nal_type  = st.header_byte[4:0];
                bu.res[bu.cnt].nal_ref_idc = st.header_byte[6:5];
                bu.cnt = bu.cnt + 3'd1;
            end
            st.nal_open         = 1'b0;
            st.emitted_zero_run = 2'd0;
        end else if (b == ZERO_BYTE) begin
            if (st.held_zero_count == HELD_MAX) begin
                // Fourth zero pushes the oldest held zero into the NAL.
                emit_byte(st, ZERO_BYTE, e_st, e_put, e_res);
                st = e_st;
                if (e_put) begin
                    bu.res[bu.cnt] = e_res;
                    bu.cnt = bu.cnt + 3'd1;
                end
            end else begin
                st.held_zero_count = st.held_zero_count + 2'd1;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (st.held_zero_count != 2'd0) begin
                    emit_byte(st, ZERO_BYTE, e_st, e_put, e_res);
                    st = e_st;
                    if (e_put) begin
                        bu.res[bu.cnt] = e_res;
                        bu.cnt = bu.cnt + 3'd1;
                    end
                    st.held_zero_count = st.held_zero_count - 2'd1;
                end
            end
            emit_byte(st, b, e_st, e_put, e_res);
            st = e_st;
            if (e_put) begin
                bu.res[bu.cnt] = e_res;
                bu.cnt = bu.cnt + 3'd1;
            end
        end

        if (i_in.data.stream_end) begin
            for (int i = 0; i < 3; i++) begin
                if (st.held_zero_count != 2'd0) begin
                    emit_byte(st, ZERO_BYTE, e_st, e_put, e_res);
                    st = e_st;
                    if (e_put) begin
                        bu.res[bu.cnt] = e_res;
                        bu.cnt = bu.cnt + 3'd1;
                    end
                    st.held_zero_count = st.held_zero_count - 2'd1;
                end
            end
            if (st.nal_open) begin
                bu.res[bu.cnt]             = '0;
                bu.res[bu.cnt].item_kind   = KIND_MARKER;
                bu.res[bu.cnt].nal_type    = st.header_byte[4:0];
                bu.res[bu.cnt].nal_ref_idc = st.header_byte[6:5];
                bu.cnt = bu.cnt + 3'd1;
            end
            st.nal_open         = 1'b0;
            st.emitted_zero_run = 2'd0;
            st.held_zero_count  = 2'd0;
        end

        n_st    = st;
        o_burst = bu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

endmodule

[rtl/core/annexb_queue.sv]
// Short FIFO of result bursts between the front and back ends.
// Depends on annexb_pkg.
`timescale 1ns / 1ps

module annexb_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  annexb_pkg::t_burst i_burst,
    input  logic               i_pop,
    output annexb_pkg::t_burst o_head,
    output annexb_pkg::t_qstat o_qstat
);
    import annexb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_burst          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[rtl/core/annexb_back.sv]
// Back end: walks the head burst of the queue and presents one result
// item per cycle unless o_out is stalled. Depends on annexb_pkg and annexb_stream_if.
`timescale 1ns / 1ps

module annexb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  annexb_pkg::t_burst i_head,
    input  annexb_pkg::t_qstat i_qstat,
    output logic               o_pop,
    annexb_stream_if.source    o_out
);
    import annexb_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             is_last;
    logic             accept;

    assign is_last = (r_idx == i_head.cnt - IDX_W'(1));
    assign accept  = o_out.valid && o_out.ready;
    assign o_pop   = accept && is_last;

    always_comb begin
        o_out.valid         = !i_qstat.empty;
        o_out.data          = i_head.res[r_idx];
        o_out.data.run_last = is_last;
        n_idx               = r_idx;
        if (accept) begin
            n_idx = is_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

[rtl/core/annexb_nal_splitter_top.sv]
// H.264 Annex B NAL splitter, top level.
// Depends on annexb_pkg, annexb_stream_if, annexb_front, annexb_queue, annexb_back.
//
// Usage:
// i_in carries one raw stream byte per item (data_byte, stream_end); o_out
// carries one result item per handshake: a NAL payload byte with emulation
// prevention removed, or an end-of-NAL marker, each tagged with the NAL type
// and ref_idc of the current header byte. run_last flags the final result
// item caused by one input byte.
// Each input byte causes zero to five result items. The front end turns a
// byte into a whole burst in the cycle it is accepted and writes it into a
// QUEUE_DEPTH-entry queue; bytes that cause nothing take no queue slot.
// A byte's burst is registered in the queue; its first result reaches o_out once
// earlier bursts are taken. i_in takes one byte per cycle while the queue has a
// free slot; o_out delivers one result per cycle unless stalled, so the
// sustained input rate is one byte per cycle while bursts average one result.
// When the receiver stalls o_out, the current item holds steady and the queue
// fills; i_in.ready drops only once the queue is full.
// Reset (synchronous, active low) empties the queue and clears the held-zero
// count, zero run, open-NAL flag and header byte.
`timescale 1ns / 1ps

module annexb_nal_splitter_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    annexb_stream_if.sink   i_in,
    annexb_stream_if.source o_out
);
    import annexb_pkg::*;

    // Burst handed from the front end to the queue.
    logic   push;
    t_burst push_burst;

    // Queue head, seen by the back end, and status, seen by both ends.
    t_burst head;
    t_qstat qstat;
    logic   pop;

    annexb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_burst (push_burst)
    );

    annexb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_burst (push_burst),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // The back end pops a burst only when its final result is taken.
    annexb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[rtl/core/annexb_chk.sv]
// Port-level checker for the Annex B NAL splitter and its bind statement.
// Depends on annexb_stream_if and annexb_nal_splitter_top_assert.svh.
`timescale 1ns / 1ps

module annexb_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    annexb_stream_if.sink   i_in,
    annexb_stream_if.source i_out
);
    `include "annexb_nal_splitter_top_assert.svh"

    `ANX_ASSERT_NXT(a_out_valid_holds, i_out.valid && !i_out.ready, i_out.valid,
        "o_out valid dropped while stalled")
    `ANX_ASSERT_NXT(a_out_data_holds, i_out.valid && !i_out.ready, $stable(i_out.data),
        "o_out item changed while stalled")
    `ANX_ASSERT_IMP(a_marker_shape, i_out.valid && i_out.data.item_kind,
        i_out.data.run_last && i_out.data.payload_byte == 8'h00 && !i_out.data.nal_first,
        "end marker is malformed or not last")
    `ANX_ASSERT_IMP(a_reset_empty, $past(!i_rst_n), i_in.ready && !i_out.valid,
        "block not empty after reset")

endmodule

bind annexb_nal_splitter_top annexb_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .i_out   (o_out)
);
